@@ design/dtps_pkg.sv @@
// Shared types, constants and the parameter table for the DDR timing selector.
// Used by every module of ddr_timing_param_select; depends on nothing.
package dtps_pkg;

  // Table geometry
  localparam int ROWS_PER_CONTROLLER = 20;
  localparam int NUM_CONTROLLERS     = 2;
  localparam int SEED_ROWS           = 10;
  localparam int IDX_W               = $clog2(ROWS_PER_CONTROLLER);
  localparam int SEED_IDX_W          = $clog2(SEED_ROWS);

  // Field widths
  localparam int CTRL_W  = 1;
  localparam int RANK_W  = 3;
  localparam int RATE_W  = 12;
  localparam int CLK_W   = 4;
  localparam int CPO_W   = 5;
  localparam int WDD_W   = 3;

  // Fallback rate thresholds in MHz
  localparam logic [RATE_W-1:0] RATE_333 = RATE_W'(333);
  localparam logic [RATE_W-1:0] RATE_400 = RATE_W'(400);
  localparam logic [RATE_W-1:0] RATE_533 = RATE_W'(533);
  localparam logic [RATE_W-1:0] RATE_667 = RATE_W'(667);

  // Fallback CPO codes
  localparam logic [CPO_W-1:0] CPO_LE_333    = CPO_W'(5'h07);
  localparam logic [CPO_W-1:0] CPO_LE_400    = CPO_W'(5'h09);
  localparam logic [CPO_W-1:0] CPO_LE_533    = CPO_W'(5'h0b);
  localparam logic [CPO_W-1:0] CPO_LE_667_C0 = CPO_W'(5'h0a);
  localparam logic [CPO_W-1:0] CPO_LE_667_CN = CPO_W'(5'h0b);
  localparam logic [CPO_W-1:0] CPO_HI_C0     = CPO_W'(5'h0c);
  localparam logic [CPO_W-1:0] CPO_HI_CN     = CPO_W'(5'h0d);

  // Fallback clock adjust and write delay settings
  localparam logic [CLK_W-1:0] CLK_SLOW    = CLK_W'(6);
  localparam logic [CLK_W-1:0] CLK_FAST    = CLK_W'(1);
  localparam logic [WDD_W-1:0] WDD_SLOW    = WDD_W'(3);
  localparam logic [WDD_W-1:0] WDD_FAST_C0 = WDD_W'(5);
  localparam logic [WDD_W-1:0] WDD_FAST_CN = WDD_W'(6);

  // One table row
  typedef struct packed {
    logic [RATE_W-1:0] lo;
    logic [RATE_W-1:0] hi;
    logic [RANK_W-1:0] ranks;
    logic [CLK_W-1:0]  clk;
    logic [CPO_W-1:0]  cpo;
    logic [WDD_W-1:0]  wdd;
    logic              t2;
  } row_t;

  // Selected settings
  typedef struct packed {
    logic [CLK_W-1:0] clk;
    logic [CPO_W-1:0] cpo;
    logic [WDD_W-1:0] wdd;
    logic             t2;
  } setting_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_DONE
  } state_t;

  // Fixed rows per controller; rows past these read as zero
  localparam row_t SEED_TABLE [0:1][0:SEED_ROWS-1] = '{
    '{
      '{12'd0,   12'd333, 3'd2, 4'd6, 5'd7,  3'd3, 1'b0},
      '{12'd334, 12'd400, 3'd2, 4'd6, 5'd9,  3'd3, 1'b0},
      '{12'd401, 12'd549, 3'd2, 4'd7, 5'd7,  3'd3, 1'b0},
      '{12'd550, 12'd680, 3'd2, 4'd1, 5'd10, 3'd5, 1'b0},
      '{12'd681, 12'd850, 3'd2, 4'd1, 5'd12, 3'd5, 1'b1},
      '{12'd0,   12'd333, 3'd1, 4'd6, 5'd7,  3'd3, 1'b0},
      '{12'd334, 12'd400, 3'd1, 4'd6, 5'd9,  3'd3, 1'b0},
      '{12'd401, 12'd549, 3'd1, 4'd4, 5'd6,  3'd2, 1'b0},
      '{12'd550, 12'd680, 3'd1, 4'd1, 5'd10, 3'd5, 1'b0},
      '{12'd681, 12'd850, 3'd1, 4'd1, 5'd12, 3'd5, 1'b0}
    },
    '{
      '{12'd0,   12'd333, 3'd2, 4'd6, 5'd7,  3'd3, 1'b0},
      '{12'd334, 12'd400, 3'd2, 4'd6, 5'd9,  3'd3, 1'b0},
      '{12'd401, 12'd549, 3'd1, 4'd4, 5'd6,  3'd2, 1'b0},
      '{12'd550, 12'd680, 3'd2, 4'd1, 5'd11, 3'd6, 1'b0},
      '{12'd681, 12'd850, 3'd2, 4'd1, 5'd13, 3'd6, 1'b1},
      '{12'd0,   12'd333, 3'd1, 4'd6, 5'd7,  3'd3, 1'b0},
      '{12'd334, 12'd400, 3'd1, 4'd6, 5'd9,  3'd3, 1'b0},
      '{12'd401, 12'd549, 3'd1, 4'd1, 5'd11, 3'd3, 1'b0},
      '{12'd550, 12'd680, 3'd1, 4'd1, 5'd11, 3'd6, 1'b0},
      '{12'd681, 12'd850, 3'd1, 4'd1, 5'd13, 3'd6, 1'b0}
    }
  };

  // Look up one row of the parameter table
  function automatic row_t rom_row(input logic [CTRL_W-1:0] ctrl,
                                   input logic [IDX_W-1:0]  idx);
    row_t row;
    row = '0;
    if (int'(idx) < SEED_ROWS) begin
      row = SEED_TABLE[ctrl][idx[SEED_IDX_W-1:0]];
    end
    return row;
  endfunction

endpackage

@@ design/dtps_rom.sv @@
// Parameter table with a registered read port.
// Depends on dtps_pkg for the row type and table contents.
module dtps_rom (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [dtps_pkg::CTRL_W-1:0] rd_ctrl,
  input  logic [dtps_pkg::IDX_W-1:0]  rd_idx,
  output dtps_pkg::row_t            rd_row
);

  dtps_pkg::row_t row_r;

  // Register the addressed row
  always_ff @(posedge clk) begin
    if (rd_en) begin
      row_r <= dtps_pkg::rom_row(rd_ctrl, rd_idx);
    end
  end

  assign rd_row = row_r;

endmodule

@@ design/dtps_match.sv @@
// Shared compare unit: checks one table row against the rate and rank count.
// Depends on dtps_pkg for the row type.
module dtps_match (
  input  dtps_pkg::row_t                row,
  input  logic [dtps_pkg::RATE_W-1:0]   rate,
  input  logic [dtps_pkg::RANK_W-1:0]   ranks,
  output logic                          hit
);

  // Inclusive range check plus exact rank match
  assign hit = (rate >= row.lo) && (rate <= row.hi) && (ranks == row.ranks);

endmodule

@@ design/dtps_fallback.sv @@
// Fallback settings used when no table row matches.
// Depends on dtps_pkg for thresholds, codes and the setting type.
module dtps_fallback (
  input  logic [dtps_pkg::CTRL_W-1:0] ctrl,
  input  logic [dtps_pkg::RATE_W-1:0] rate,
  output dtps_pkg::setting_t          setting
);

  logic nonzero_ctrl;

  assign nonzero_ctrl = (ctrl != '0);

  // Pick settings from the rate thresholds
  always_comb begin
    setting.t2  = 1'b1;
    setting.clk = (rate > dtps_pkg::RATE_533) ? dtps_pkg::CLK_FAST : dtps_pkg::CLK_SLOW;
    if (rate <= dtps_pkg::RATE_533) begin
      setting.wdd = dtps_pkg::WDD_SLOW;
    end else begin
      setting.wdd = nonzero_ctrl ? dtps_pkg::WDD_FAST_CN : dtps_pkg::WDD_FAST_C0;
    end
    priority if (rate <= dtps_pkg::RATE_333) begin
      setting.cpo = dtps_pkg::CPO_LE_333;
    end else if (rate <= dtps_pkg::RATE_400) begin
      setting.cpo = dtps_pkg::CPO_LE_400;
    end else if (rate <= dtps_pkg::RATE_533) begin
      setting.cpo = dtps_pkg::CPO_LE_533;
    end else if (rate <= dtps_pkg::RATE_667) begin
      setting.cpo = nonzero_ctrl ? dtps_pkg::CPO_LE_667_CN : dtps_pkg::CPO_LE_667_C0;
    end else begin
      setting.cpo = nonzero_ctrl ? dtps_pkg::CPO_HI_CN : dtps_pkg::CPO_HI_C0;
    end
  end

endmodule

@@ design/ddr_timing_param_select.sv @@
// Top level of the DDR timing parameter selector: sequencer and output beat.
// Depends on dtps_pkg, dtps_rom, dtps_match and dtps_fallback.
//
// Each input beat walks the chosen controller's 20-row table one row at a time,
// each row a registered table read (ST_READ), then a compare in the shared match
// unit (ST_CMP), stopping at the first row whose rate range holds the rate and
// whose rank count matches. A miss on every row uses the fixed fallback settings
// with table_hit low. From ST_DONE the result moves into the output register
// once that register is empty or out_ready is high. in_ready is high only
// between items; a finished result may wait in the output register while the
// next beat is taken.
module ddr_timing_param_select (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [dtps_pkg::CTRL_W-1:0]       in_controller,
  input  logic [dtps_pkg::RANK_W-1:0]       in_rank_count,
  input  logic [dtps_pkg::RATE_W-1:0]       in_data_rate_mhz,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dtps_pkg::CLK_W-1:0]        out_clock_adjust,
  output logic [dtps_pkg::CPO_W-1:0]        out_cas_to_preamble,
  output logic [dtps_pkg::WDD_W-1:0]        out_write_delay,
  output logic                              out_two_t_enable,
  output logic                              out_table_hit
);

  dtps_pkg::state_t st_r, st_nxt;

  logic [dtps_pkg::CTRL_W-1:0] ctrl_r;
  logic [dtps_pkg::RANK_W-1:0] ranks_r;
  logic [dtps_pkg::RATE_W-1:0] rate_r;
  logic [dtps_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  dtps_pkg::setting_t          res_r, res_nxt;
  logic                        hit_r, hit_nxt;

  dtps_pkg::setting_t          out_set_r;
  logic                        out_hit_r;
  logic                        out_valid_r;

  dtps_pkg::row_t              row;
  dtps_pkg::setting_t          fb_set;
  logic                        row_hit;
  logic                        ctrl_ok;
  logic                        last_row;
  logic                        in_fire;
  logic                        out_load;
  logic                        rd_en;

  assign in_fire  = in_valid && in_ready;
  assign ctrl_ok  = (int'(in_controller) < dtps_pkg::NUM_CONTROLLERS);
  assign last_row = (int'(idx_r) == dtps_pkg::ROWS_PER_CONTROLLER - 1);

  dtps_rom u_rom (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_ctrl (ctrl_r),
    .rd_idx  (idx_r),
    .rd_row  (row)
  );

  dtps_match u_match (
    .row   (row),
    .rate  (rate_r),
    .ranks (ranks_r),
    .hit   (row_hit)
  );

  dtps_fallback u_fallback (
    .ctrl    (ctrl_r),
    .rate    (rate_r),
    .setting (fb_set)
  );

  // Next state of the row walk
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      dtps_pkg::ST_IDLE: begin
        if (in_fire) begin
          st_nxt = ctrl_ok ? dtps_pkg::ST_READ : dtps_pkg::ST_DONE;
        end
      end
      dtps_pkg::ST_READ: st_nxt = dtps_pkg::ST_CMP;
      dtps_pkg::ST_CMP: begin
        if (row_hit || last_row) begin
          st_nxt = dtps_pkg::ST_DONE;
        end else begin
          st_nxt = dtps_pkg::ST_READ;
        end
      end
      dtps_pkg::ST_DONE: begin
        if (out_load) begin
          st_nxt = dtps_pkg::ST_IDLE;
        end
      end
      default: st_nxt = dtps_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: input ready, table read, row index, pending result, output load
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    out_load = 1'b0;
    idx_nxt  = idx_r;
    res_nxt  = res_r;
    hit_nxt  = hit_r;
    unique case (st_r)
      dtps_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        idx_nxt  = '0;
        hit_nxt  = 1'b0;
      end
      dtps_pkg::ST_READ: rd_en = 1'b1;
      dtps_pkg::ST_CMP: begin
        idx_nxt = idx_r + 1'b1;
        if (row_hit) begin
          res_nxt = '{clk: row.clk, cpo: row.cpo, wdd: row.wdd, t2: row.t2};
          hit_nxt = 1'b1;
        end
      end
      dtps_pkg::ST_DONE: out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= dtps_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      hit_r <= hit_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture the input beat and hold the walk's working values
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ctrl_r  <= in_controller;
      ranks_r <= in_rank_count;
      rate_r  <= in_data_rate_mhz;
    end
    idx_r <= idx_nxt;
    res_r <= res_nxt;
  end

  // Load the output beat, table row on a hit, fallback otherwise
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_set_r <= hit_r ? res_r : fb_set;
      out_hit_r <= hit_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_clock_adjust    = out_set_r.clk;
  assign out_cas_to_preamble = out_set_r.cpo;
  assign out_write_delay     = out_set_r.wdd;
  assign out_two_t_enable    = out_set_r.t2;
  assign out_table_hit       = out_hit_r;

endmodule
